// ===== hw/rtl/okl_pkg.sv =====
// Shared types and codes for the ordered key list.
// Holds command and status codes, per-cell operations, sequencer states and the cell control struct.
// No dependencies.
`default_nettype none

package okl_pkg;

  // Key width and count width (count covers capacities up to 127)
  localparam int unsigned KEY_W = 32;
  localparam int unsigned CNT_W = 7;

  // Command codes carried in tuser
  typedef enum logic [2:0] {
    ACT_INSERT    = 3'd0,
    ACT_DEL_KEY   = 3'd1,
    ACT_DEL_FIRST = 3'd2,
    ACT_DEL_LAST  = 3'd3,
    ACT_READ      = 3'd4
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,  // keep key
    OP_PUSH   = 2'd1,  // take key from front-side neighbor
    OP_PULL   = 2'd2,  // take key from back-side neighbor where hit
    OP_ROTATE = 2'd3   // shift toward front, tail takes the head key
  } cell_op_e;

  // Sequencer states
  typedef enum logic {
    SQ_IDLE,
    SQ_READ
  } seq_state_e;

  // Control broadcast to all cells
  typedef struct packed {
    cell_op_e               op;
    logic                   match_en;
    logic [KEY_W-1:0]       key;
    logic [CNT_W-1:0]       count;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ordered_key_list.sv =====
// Top level of the ordered key list: command sequencer, fill count and result register.
// Instantiates a chain of okl_cell; depends on okl_pkg.
//
// Usage:
//   Commands enter on the s_axis channel: tuser holds the action, tdata the key.
//   Results leave on the m_axis channel: tdata holds out_key, status and
//   entry_count; tlast marks the final result of a command.
//   Insert, delete-key, delete-first, delete-last and unknown actions finish in
//   the cycle they are accepted and give one result, registered on the next edge.
//   Delete-key searches all cells at once through the hit chain.
//   Read out gives one result per held key, front to back, one per cycle
//   while the receiver accepts; the cell chain rotates by one entry in each
//   such cycle and is back in order after the last key. An empty list gives
//   a single result with status miss. A new command is taken once the
//   sequencer is idle and the result register is empty or being drained in
//   that cycle; an update command or an empty read out leaves the sequencer
//   idle, while a non-empty read out blocks new commands until its last key.
//   When the receiver stalls, the result register holds and the sequencer waits.
//   Reset empties the list and clears the result register; keys need no clear.
`default_nettype none

module ordered_key_list #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,   // [31:0] key
  input  wire  [2:0]  s_axis_tuser_i,   // [2:0] action
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] out_key, [33:32] status, [39:34] entry_count
  output logic        m_axis_tlast_o
);
  import okl_pkg::*;

  seq_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic             in_fire;
  logic             out_free;
  logic             found;
  cell_ctrl_t       ctrl;
  logic             head_hit;
  logic             load;
  logic [KEY_W-1:0] res_key;
  status_e          res_status;
  logic             res_last;
  logic             rd_last;
  action_e          action;

  logic [KEY_W-1:0] cell_key [CAPACITY];
  logic             hit      [CAPACITY+1];

  logic             m_valid_q;
  logic [39:0]      m_data_q;
  logic             m_last_q;

  assign action   = action_e'(s_axis_tuser_i);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign found    = hit[CAPACITY];
  assign rd_last  = rd_q == (count_q - CNT_W'(1));

  assign s_axis_tready_o = (state_q == SQ_IDLE) && out_free;

  // Chain of cells
  assign hit[0] = head_hit;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] front_key;
    logic [KEY_W-1:0] back_key;
    if (i == 0) begin : g_first
      assign front_key = ctrl.key;
    end else begin : g_mid
      assign front_key = cell_key[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign back_key = '0;
    end else begin : g_inner
      assign back_key = cell_key[i+1];
    end
    okl_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .front_key_i (front_key),
      .back_key_i  (back_key),
      .head_key_i  (cell_key[0]),
      .hit_i       (hit[i]),
      .hit_o       (hit[i+1]),
      .key_o       (cell_key[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (in_fire && action == ACT_READ && count_q != '0) begin
          state_d = SQ_READ;
        end
      end
      SQ_READ: begin
        if (out_free && rd_last) begin
          state_d = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // Cell control
  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.match_en = 1'b0;
    ctrl.key      = s_axis_tdata_i;
    ctrl.count    = count_q;
    head_hit      = 1'b0;
    unique case (state_q)
      SQ_IDLE: begin
        if (in_fire) begin
          unique case (action)
            ACT_INSERT: begin
              if (count_q < CNT_W'(CAPACITY)) begin
                ctrl.op = OP_PUSH;
              end
            end
            ACT_DEL_KEY: begin
              ctrl.op       = OP_PULL;
              ctrl.match_en = 1'b1;
            end
            ACT_DEL_FIRST: begin
              if (count_q != '0) begin
                ctrl.op  = OP_PULL;
                head_hit = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      SQ_READ: begin
        if (out_free) begin
          ctrl.op = OP_ROTATE;
        end
      end
      default: ;
    endcase
  end

  // Count update and result
  always_comb begin
    count_d    = count_q;
    rd_d       = rd_q;
    load       = 1'b0;
    res_key    = '0;
    res_status = ST_MISS;
    res_last   = 1'b1;
    unique case (state_q)
      SQ_IDLE: begin
        if (in_fire) begin
          load = 1'b1;
          unique case (action)
            ACT_INSERT: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                res_status = ST_FULL;
              end else begin
                count_d    = count_q + CNT_W'(1);
                res_status = ST_DONE;
              end
            end
            ACT_DEL_KEY: begin
              if (found) begin
                count_d    = count_q - CNT_W'(1);
                res_status = ST_DONE;
              end
            end
            ACT_DEL_FIRST: begin
              if (count_q != '0) begin
                count_d    = count_q - CNT_W'(1);
                res_status = ST_DONE;
              end
            end
            ACT_DEL_LAST: begin
              if (count_q != '0) begin
                count_d    = count_q - CNT_W'(1);
                res_status = ST_DONE;
              end
            end
            ACT_READ: begin
              // empty list answers at once, otherwise the read sequence runs
              if (count_q != '0) begin
                load = 1'b0;
                rd_d = '0;
              end
            end
            default: res_status = ST_MISS;
          endcase
        end
      end
      SQ_READ: begin
        if (out_free) begin
          load       = 1'b1;
          res_key    = cell_key[0];
          res_status = ST_DONE;
          res_last   = rd_last;
          rd_d       = rd_q + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SQ_IDLE;
      count_q   <= '0;
      rd_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rd_q    <= rd_d;
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= {count_d[5:0], res_status, res_key};
      m_last_q <= res_last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/okl_cell.sv =====
// One storage cell of the ordered key list chain.
// Holds one key, compares it against the broadcast key and shifts with its neighbors.
// Depends on okl_pkg.
`default_nettype none

module okl_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire                       clk_i,
  input  wire okl_pkg::cell_ctrl_t  ctrl_i,
  input  wire [okl_pkg::KEY_W-1:0]  front_key_i,  // neighbor nearer the front
  input  wire [okl_pkg::KEY_W-1:0]  back_key_i,   // neighbor nearer the back
  input  wire [okl_pkg::KEY_W-1:0]  head_key_i,   // key of cell 0
  input  wire                       hit_i,        // a match lies in front of this cell
  output logic                      hit_o,
  output logic [okl_pkg::KEY_W-1:0] key_o
);
  import okl_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic             valid;
  logic             tail;
  logic             match;

  // Position of this cell relative to the fill level
  assign valid = CNT_W'(Idx) < ctrl_i.count;
  assign tail  = ctrl_i.count == CNT_W'(Idx + 1);

  // Frontmost match: hit ripples toward the back
  assign match = ctrl_i.match_en && valid && (key_q == ctrl_i.key);
  assign hit_o = hit_i || match;

  // Next key
  always_comb begin
    unique case (ctrl_i.op)
      OP_HOLD:   key_d = key_q;
      OP_PUSH:   key_d = front_key_i;
      OP_PULL:   key_d = hit_o ? back_key_i : key_q;
      OP_ROTATE: key_d = tail ? head_key_i : back_key_i;
      default:   key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

`default_nettype wire
